FILE: sv/fcpf_pkg.sv
// ============================================================================
// fcpf_pkg : shared types and constants of the file chunk packet framer
// Holds the action codes, packet kinds, header constants and the command
// record that travels from the front end through the queue to the back end.
// ============================================================================
package fcpf_pkg;

   // Input action codes
   localparam logic [1:0] ACT_NAME  = 2'd0;
   localparam logic [1:0] ACT_DATA  = 2'd1;
   localparam logic [1:0] ACT_BYTE  = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   // Packet kinds carried in header byte 9
   localparam logic [7:0] KIND_FIRST  = 8'h00;
   localparam logic [7:0] KIND_MIDDLE = 8'h01;
   localparam logic [7:0] KIND_FINAL  = 8'h02;
   localparam logic [7:0] KIND_NAME   = 8'hFF;

   // Fixed header bytes
   localparam logic [7:0] SYNC0 = 8'hEB;
   localparam logic [7:0] SYNC1 = 8'h51;
   localparam logic [7:0] MARK4 = 8'h39;

   // Header length and length offset in bytes 2,3
   localparam int unsigned HDR_BYTES = 12;
   localparam logic [11:0] LEN_OFFSET = 12'd8;

   // Largest payload length; longer requests saturate to it
   localparam int unsigned MAX_CHUNK = 1024;

   // Queue depth between front and back end
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      OP_HEADER,
      OP_BYTE
   } cmd_op_type;

   // One command per input item that produces output
   typedef struct packed {
      cmd_op_type  op;
      logic [10:0] len;        // header: payload length
      logic [7:0]  kind;       // header: packet kind
      logic [31:0] size;       // header: file size
      logic [7:0]  data;       // byte: payload byte
      logic        last;       // byte: last payload byte of packet
   } cmd_type;

   // Queue status seen by the front and back end
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

FILE: sv/fcpf_front.sv
// ============================================================================
// fcpf_front : input classifier and transfer bookkeeping
// Accepts request transactions, tracks file size, running total, first
// packet flag and remaining payload, and issues one command per item that produces output.
// ============================================================================
module fcpf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [31:0]               req_file_size,
   input  logic [10:0]               req_chunk_length,
   input  logic [7:0]                req_data_byte,
   input  fcpf_pkg::queue_status_type q_status,
   output logic                      push,
   output fcpf_pkg::cmd_type         push_cmd
);
   import fcpf_pkg::*;

   logic [31:0] total_size_ff, total_size_in;
   logic [31:0] sent_total_ff, sent_total_in;
   logic        first_done_ff, first_done_in;
   logic [10:0] bytes_left_ff, bytes_left_in;
   logic        accept;
   logic [10:0] len_sat;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // Saturate the requested length
   assign len_sat = (32'(req_chunk_length) > 32'(MAX_CHUNK)) ? 11'(MAX_CHUNK)
                                                            : req_chunk_length;

   // Classify the item and update transfer state
   always_comb begin
      logic [31:0] sum;
      logic        hit;
      sum           = sent_total_ff + 32'(len_sat);
      hit           = (sum == total_size_ff);
      total_size_in = total_size_ff;
      sent_total_in = sent_total_ff;
      first_done_in = first_done_ff;
      bytes_left_in = bytes_left_ff;
      push          = 1'b0;
      push_cmd      = '0;
      push_cmd.op   = OP_HEADER;
      push_cmd.len  = len_sat;
      push_cmd.size = total_size_ff;
      push_cmd.data = req_data_byte;
      push_cmd.last = (bytes_left_ff == 11'd1);
      push_cmd.kind = KIND_NAME;
      if (accept) begin
         unique case (req_action)
            ACT_NAME: begin
               total_size_in = req_file_size;
               sent_total_in = '0;
               first_done_in = 1'b0;
               bytes_left_in = len_sat;
               push_cmd.size = req_file_size;
               push          = 1'b1;
            end
            ACT_DATA: begin
               sent_total_in = sum;
               bytes_left_in = len_sat;
               if (!first_done_ff) begin
                  push_cmd.kind = hit ? KIND_FINAL : KIND_FIRST;
                  first_done_in = 1'b1;
               end else if (hit) begin
                  push_cmd.kind = KIND_FINAL;
                  first_done_in = 1'b0;
               end else begin
                  push_cmd.kind = KIND_MIDDLE;
               end
               push = 1'b1;
            end
            ACT_BYTE: begin
               // drop stray bytes outside a packet
               if (bytes_left_ff != 11'd0) begin
                  push_cmd.op   = OP_BYTE;
                  bytes_left_in = bytes_left_ff - 11'd1;
                  push          = 1'b1;
               end
            end
            ACT_SPARE: begin
               // ignore the unused action
            end
            default: begin
            end
         endcase
      end
   end

   // Hold transfer state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_size_ff <= '0;
         sent_total_ff <= '0;
         first_done_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else begin
         total_size_ff <= total_size_in;
         sent_total_ff <= sent_total_in;
         first_done_ff <= first_done_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

FILE: sv/fcpf_queue.sv
// ============================================================================
// fcpf_queue : command queue between front and back end
// A small register queue; head entry is visible to the back end directly.
// ============================================================================
module fcpf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fcpf_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output fcpf_pkg::cmd_type          head_cmd,
   output fcpf_pkg::queue_status_type status
);
   import fcpf_pkg::*;

   cmd_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_cmd     = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/fcpf_back.sv
// ============================================================================
// fcpf_back : byte sequencer
// Expands queued commands into header, payload and checksum bytes, keeps
// the running XOR and drives the registered response channel.
// ============================================================================
module fcpf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fcpf_pkg::cmd_type          head_cmd,
   input  fcpf_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_frame_end,
   output logic                       rsp_run_last
);
   import fcpf_pkg::*;

   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  xor_ff, xor_in;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_fe_ff;
   logic        rsp_last_ff;
   logic        out_adv;
   logic        produce;
   logic [7:0]  cur_byte;
   logic        cur_fe;
   logic        cur_last;

   assign out_adv = !rsp_valid_ff || rsp_ready;
   assign produce = !q_status.empty && out_adv;
   assign pop     = produce && cur_last;

   // Select the current byte and the checksum update
   always_comb begin
      logic [11:0] l8;
      logic [7:0]  hbyte;
      l8       = {1'b0, head_cmd.len} + LEN_OFFSET;
      hbyte    = SYNC0;
      cur_byte = '0;
      cur_fe   = 1'b0;
      cur_last = 1'b0;
      xor_in   = xor_ff;
      unique case (idx_ff)
         4'd0:    hbyte = SYNC0;
         4'd1:    hbyte = SYNC1;
         4'd2:    hbyte = l8[7:0];
         4'd3:    hbyte = {4'b0, l8[11:8]};
         4'd4:    hbyte = MARK4;
         4'd5:    hbyte = head_cmd.size[7:0];
         4'd6:    hbyte = head_cmd.size[15:8];
         4'd7:    hbyte = head_cmd.size[23:16];
         4'd8:    hbyte = head_cmd.size[31:24];
         4'd9:    hbyte = head_cmd.kind;
         4'd10:   hbyte = head_cmd.len[7:0];
         4'd11:   hbyte = {5'b0, head_cmd.len[10:8]};
         default: hbyte = xor_ff;
      endcase
      unique case (head_cmd.op)
         OP_HEADER: begin
            if (idx_ff == 4'd0) begin
               cur_byte = hbyte;
               xor_in   = '0;
            end else if (32'(idx_ff) < HDR_BYTES) begin
               cur_byte = hbyte;
               xor_in   = xor_ff ^ hbyte;
               cur_last = (idx_ff == 4'd11) && (head_cmd.len != 11'd0);
            end else begin
               // zero length packet: checksum right after header
               cur_byte = xor_ff;
               cur_fe   = 1'b1;
               cur_last = 1'b1;
            end
         end
         OP_BYTE: begin
            if (idx_ff == 4'd0) begin
               cur_byte = head_cmd.data;
               xor_in   = xor_ff ^ head_cmd.data;
               cur_last = !head_cmd.last;
            end else begin
               cur_byte = xor_ff;
               cur_fe   = 1'b1;
               cur_last = 1'b1;
            end
         end
         default: begin
         end
      endcase
      idx_in = cur_last ? 4'd0 : idx_ff + 4'd1;
   end

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         xor_ff <= '0;
      end else if (produce) begin
         idx_ff <= idx_in;
         xor_ff <= xor_in;
      end
   end

   // Hold the response register until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= produce;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_byte_ff <= cur_byte;
         rsp_fe_ff   <= cur_fe;
         rsp_last_ff <= cur_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_frame_end = rsp_fe_ff;
   assign rsp_run_last  = rsp_last_ff;

endmodule

FILE: sv/file_chunk_packet_framer.sv
// ============================================================================
// file_chunk_packet_framer : frames a file transfer into byte packets
// Name and data start items open packets with a 12-byte header, payload
// bytes pass through, and an XOR checksum closes each packet.
// ============================================================================
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+-----------
//   req     | in        | action, file_size, chunk_length, data   | valid/ready
//   rsp     | out       | out_byte, frame_end, run_last           | valid/ready
//
// A start item gives the 12 header bytes, plus the checksum at zero length;
// a payload byte gives itself, plus the checksum if it closes the packet.
// Requests are taken one per cycle while the 4-entry command queue has room;
// the back end sequencer emits one byte per cycle into the response register
// unless stalled. Reset is synchronous and clears all transfer state, queue
// and response. A response stall fills the queue and then drops req_ready.
//
module file_chunk_packet_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_file_size,
   input  logic [10:0] req_chunk_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_last
);
   import fcpf_pkg::*;

   queue_status_type q_status;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;

   fcpf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_file_size    (req_file_size),
      .req_chunk_length (req_chunk_length),
      .req_data_byte    (req_data_byte),
      .q_status         (q_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   fcpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   fcpf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_run_last  (rsp_run_last)
   );

   // A checksum byte always ends the transaction's results
   a_fe_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("checksum byte without run_last");

   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("command queue overflow");

   // Never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("command queue underflow");

   // Response channel is empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule
